// ===== design/qsat_pkg.sv =====
// shared constants, types and sequencer states for the quad separating axis test
`default_nettype none

package qsat_pkg;

   // coordinate width inside the core; taken from the low bits of each 16-bit field
   localparam int COORD_BITS = 16;
   localparam int CORNER_W   = 16;
   localparam int EDGE_W     = COORD_BITS + 1;
   localparam int PROD_W     = COORD_BITS + EDGE_W;
   localparam int DOT_W      = PROD_W + 1;
   localparam int SLOTS      = 8;
   localparam int SLOT_W     = $clog2(SLOTS);

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic signed [EDGE_W-1:0]     edge_type;
   typedef logic signed [PROD_W-1:0]     prod_type;
   typedef logic signed [DOT_W-1:0]      dot_type;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EDGE_A,
      ST_EDGE_B,
      ST_MUL_X,
      ST_MUL_Y,
      ST_COMPARE,
      ST_TEST,
      ST_RESULT
   } state_type;

   // controls from the sequencer to the projection unit
   typedef struct packed {
      logic load_a;
      logic load_b;
      logic mul_x;
      logic mul_y;
      logic compare;
      logic first;
      logic quad;
   } proj_ctrl_type;

endpackage

`default_nettype wire

// ===== design/qsat_proj_unit.sv =====
// projection unit: edge axis, shared multiplier, per-quad min/max and separation check
`default_nettype none

module qsat_proj_unit
   import qsat_pkg::*;
(
   input  wire logic          clock,
   input  wire proj_ctrl_type ctrl,
   input  wire coord_type     rd_x,
   input  wire coord_type     rd_y,
   output logic               separated
);

   coord_type a_x_ff, a_y_ff;
   edge_type  ax_ff, ay_ff;
   prod_type  prod_ff, prod_in;
   prod_type  acc_ff;
   coord_type mul_coord;
   edge_type  mul_axis;
   dot_type   dot;
   dot_type   lo_ff [2];
   dot_type   hi_ff [2];

   // shared multiplier: x times axis x, then y times axis y
   always_comb begin
      if (ctrl.mul_y) begin
         mul_coord = rd_y;
         mul_axis  = ay_ff;
      end else begin
         mul_coord = rd_x;
         mul_axis  = ax_ff;
      end
      prod_in = PROD_W'(mul_coord) * PROD_W'(mul_axis);
   end

   assign dot = DOT_W'(acc_ff) + DOT_W'(prod_ff);

   // axis build, products and running interval per quad
   always_ff @(posedge clock) begin
      if (ctrl.load_a) begin
         a_x_ff <= rd_x;
         a_y_ff <= rd_y;
      end
      if (ctrl.load_b) begin
         ax_ff <= EDGE_W'(rd_y) - EDGE_W'(a_y_ff);
         ay_ff <= EDGE_W'(a_x_ff) - EDGE_W'(rd_x);
      end
      if (ctrl.mul_x || ctrl.mul_y) begin
         prod_ff <= prod_in;
      end
      if (ctrl.mul_y) begin
         acc_ff <= prod_ff;
      end
      if (ctrl.compare) begin
         if (ctrl.first || dot < lo_ff[ctrl.quad]) begin
            lo_ff[ctrl.quad] <= dot;
         end
         if (ctrl.first || dot > hi_ff[ctrl.quad]) begin
            hi_ff[ctrl.quad] <= dot;
         end
      end
   end

   // touching intervals count as separated
   assign separated = (lo_ff[0] >= hi_ff[1]) || (lo_ff[1] >= hi_ff[0]);

endmodule

`default_nettype wire

// ===== design/quad_separating_axis_test_core.sv =====
// Overlap test of two convex quadrilaterals by the separating axis method.
// Input channel req_*: one corner per transaction; slot 0-3 is the first quad in
// order, slot 4-7 the second. The corner is written to an eight-entry store at
// acceptance. A transaction with req_evaluate set then runs the test over the
// whole store and yields one rsp_* transaction; without it no result follows.
// A store-only transaction leaves req_ready high.
// An evaluating transaction steps one shared multiplier through each axis:
// build the axis from the edge endpoints, then per corner the x product, the y
// product and the sum with min/max update over eight corners, then the interval
// test; the test stops at the first separating axis, at most eight axes are
// swept, and a last step loads the result register.
// req_ready is low while the test runs. The result register lets a corner be
// accepted while an earlier result still waits; when the receiver stalls and a
// new result is ready, the sequencer holds it until rsp_ready frees the register.
// Synchronous reset clears the store to corner (0,0) in every slot, empties the
// result register and returns the sequencer to idle.
`default_nettype none

module quad_separating_axis_test_core
   import qsat_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic [SLOT_W-1:0]   req_corner_slot,
   input  wire logic signed [CORNER_W-1:0] req_corner_x,
   input  wire logic signed [CORNER_W-1:0] req_corner_y,
   input  wire logic                req_evaluate,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic                     rsp_overlap
);

   state_type     state_ff, state_in;
   coord_type     store_x_ff [SLOTS];
   coord_type     store_y_ff [SLOTS];
   logic [SLOT_W-1:0] axis_ff, corner_ff, rd_addr;
   logic          verdict_ff;
   logic          rsp_valid_ff, rsp_overlap_ff;
   logic          req_take, rsp_free, separated;
   proj_ctrl_type ctrl;
   coord_type     rd_x, rd_y;

   assign req_take = req_valid && req_ready;
   assign rsp_free = !rsp_valid_ff || rsp_ready;

   // corner store, written on each accepted transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) begin
            store_x_ff[i] <= '0;
            store_y_ff[i] <= '0;
         end
      end else if (req_take) begin
         store_x_ff[req_corner_slot] <= req_corner_x[COORD_BITS-1:0];
         store_y_ff[req_corner_slot] <= req_corner_y[COORD_BITS-1:0];
      end
   end

   // single read port: edge endpoints or the corner being projected
   always_comb begin
      unique case (state_ff)
         ST_EDGE_A: rd_addr = axis_ff;
         ST_EDGE_B: rd_addr = {axis_ff[SLOT_W-1], axis_ff[SLOT_W-2:0] + 1'b1};
         default:   rd_addr = corner_ff;
      endcase
   end

   assign rd_x = store_x_ff[rd_addr];
   assign rd_y = store_y_ff[rd_addr];

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take && req_evaluate) state_in = ST_EDGE_A;
         end
         ST_EDGE_A:  state_in = ST_EDGE_B;
         ST_EDGE_B:  state_in = ST_MUL_X;
         ST_MUL_X:   state_in = ST_MUL_Y;
         ST_MUL_Y:   state_in = ST_COMPARE;
         ST_COMPARE: begin
            if (corner_ff == SLOT_W'(SLOTS - 1)) state_in = ST_TEST;
            else                                 state_in = ST_MUL_X;
         end
         ST_TEST: begin
            if (separated || axis_ff == SLOT_W'(SLOTS - 1)) state_in = ST_RESULT;
            else                                            state_in = ST_EDGE_A;
         end
         ST_RESULT: begin
            if (rsp_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      ctrl         = '0;
      req_ready    = 1'b0;
      ctrl.first   = (corner_ff[SLOT_W-2:0] == '0);
      ctrl.quad    = corner_ff[SLOT_W-1];
      unique case (state_ff)
         ST_IDLE:    req_ready    = 1'b1;
         ST_EDGE_A:  ctrl.load_a  = 1'b1;
         ST_EDGE_B:  ctrl.load_b  = 1'b1;
         ST_MUL_X:   ctrl.mul_x   = 1'b1;
         ST_MUL_Y:   ctrl.mul_y   = 1'b1;
         ST_COMPARE: ctrl.compare = 1'b1;
         default:    ;
      endcase
   end

   // state, counters and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         axis_ff      <= '0;
         corner_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_IDLE) begin
            axis_ff <= '0;
         end else if (state_ff == ST_TEST) begin
            axis_ff <= axis_ff + 1'b1;
         end
         if (state_ff == ST_EDGE_B) begin
            corner_ff <= '0;
         end else if (state_ff == ST_COMPARE) begin
            corner_ff <= corner_ff + 1'b1;
         end
         if (state_ff == ST_RESULT && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // verdict and result payload
   always_ff @(posedge clock) begin
      if (state_ff == ST_TEST) begin
         verdict_ff <= !separated;
      end
      if (state_ff == ST_RESULT && rsp_free) begin
         rsp_overlap_ff <= verdict_ff;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_overlap = rsp_overlap_ff;

   qsat_proj_unit u_proj (
      .clock     (clock),
      .ctrl      (ctrl),
      .rd_x      (rd_x),
      .rd_y      (rd_y),
      .separated (separated)
   );

   // evaluating transaction starts the axis sweep
   assert property (@(posedge clock) disable iff (reset)
      (req_take && req_evaluate) |=> (state_ff == ST_EDGE_A && axis_ff == '0))
      else $error("evaluate did not start the axis sweep");

   // a store-only transaction never produces a result
   assert property (@(posedge clock) disable iff (reset)
      (req_take && !req_evaluate && !rsp_valid_ff) |=> !rsp_valid_ff)
      else $error("result appeared without evaluate");

   // each axis projects from the first corner
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EDGE_B) |=> (state_ff == ST_MUL_X && corner_ff == '0))
      else $error("projection did not start at the first corner");

   // a finished test is delivered once the result register is free
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RESULT && rsp_free) |=> (rsp_valid && state_ff == ST_IDLE))
      else $error("result not delivered");

endmodule

`default_nettype wire
